[design/modexp_pkg.sv]
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

  // Width of the data, register and result fields.
  localparam int DATA_WIDTH = 32;

  // Default width of the arithmetic datapath.
  localparam int MOD_WIDTH_DEF = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'd1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_REDUCE,
    S_BIT,
    S_MUL_P,
    S_P_DONE,
    S_MUL_S,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // capture operands of an accepted transaction
    logic red_step;      // one step of the initial data reduction
    logic mul_start;     // set up a shift-and-add multiply
    logic mul_sel_prod;  // multiply base by product (else base by base)
    logic mul_step;      // one step of the multiply
    logic write_prod;    // product takes the multiply result
    logic write_base;    // base takes the square, exponent shifts
    logic out_load;      // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_zero;     // modulus is zero
    logic exp_lsb;    // current exponent bit
    logic step_last;  // last step of a reduction or multiply
    logic bit_last;   // last exponent bit
    logic out_busy;   // output register holds an untaken result
  } status_t;

endpackage

[design/modexp_if.sv]
// Stream interfaces for the input and result channels.
interface modexp_in_if import modexp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data_in;

  modport source (output valid, output data_in, input ready);
  modport sink   (input valid, input data_in, output ready);
endinterface

interface modexp_out_if import modexp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result;
  logic                  error;

  modport source (output valid, output result, output error, input ready);
  modport sink   (input valid, input result, input error, output ready);
endinterface

[design/modexp_dp.sv]
// Datapath: operand registers, modular add/double units, counters, output register.
module modexp_dp import modexp_pkg::*; #(
  parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [DATA_WIDTH-1:0] cfg_modulus,
  input  logic [DATA_WIDTH-1:0] cfg_exponent,
  input  logic [DATA_WIDTH-1:0] data_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] result,
  output logic                  error
);

  localparam int W  = MOD_WIDTH;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] STEP_LAST = CW'(W - 1);
  localparam logic [W-1:0]  ONE_W     = W'(1);

  logic [W-1:0]  mod_w;
  logic [W-1:0]  exp_w;
  logic [W-1:0]  data_w;
  logic [DATA_WIDTH-1:0] prod_out;

  logic [W-1:0]  mod_r;
  logic [W-1:0]  exp_r;
  logic [W-1:0]  data_r;
  logic [W-1:0]  base_r;
  logic [W-1:0]  prod_r;
  logic [W-1:0]  acc_r;
  logic [W-1:0]  mula_r;
  logic [W-1:0]  mulb_r;
  logic [CW-1:0] step_cnt;
  logic [CW-1:0] bit_cnt;

  logic [W-1:0]  red_next;
  logic [W-1:0]  acc_next;
  logic [W-1:0]  dbl_next;

  // Subtract the modulus once from a sum known to be below twice the modulus.
  function automatic logic [W-1:0] reduce_once(input logic [W:0] s, input logic [W-1:0] m);
    logic [W:0] t;
    t = (s >= {1'b0, m}) ? (s - {1'b0, m}) : s;
    return t[W-1:0];
  endfunction

  // Fit the fixed-width fields to the datapath width and back.
  generate
    if (W > DATA_WIDTH) begin : g_wide
      assign mod_w    = {{(W - DATA_WIDTH){1'b0}}, cfg_modulus};
      assign exp_w    = {{(W - DATA_WIDTH){1'b0}}, cfg_exponent};
      assign data_w   = {{(W - DATA_WIDTH){1'b0}}, data_in};
      assign prod_out = prod_r[DATA_WIDTH-1:0];
    end else if (W == DATA_WIDTH) begin : g_equal
      assign mod_w    = cfg_modulus;
      assign exp_w    = cfg_exponent;
      assign data_w   = data_in;
      assign prod_out = prod_r;
    end else begin : g_narrow
      assign mod_w    = cfg_modulus[W-1:0];
      assign exp_w    = cfg_exponent[W-1:0];
      assign data_w   = data_in[W-1:0];
      assign prod_out = {{(DATA_WIDTH - W){1'b0}}, prod_r};
    end
  endgenerate

  // Modular step units: reduction shift-in, accumulate and doubling.
  assign red_next = reduce_once({base_r, data_r[W-1]}, mod_r);
  assign acc_next = reduce_once({1'b0, acc_r} + {1'b0, mula_r}, mod_r);
  assign dbl_next = reduce_once({mula_r, 1'b0}, mod_r);

  // Operand and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_r    <= mod_w;
      exp_r    <= exp_w;
      data_r   <= data_w;
      base_r   <= '0;
      prod_r   <= (mod_w == ONE_W) ? '0 : ONE_W;
      step_cnt <= '0;
      bit_cnt  <= '0;
    end
    if (cmd.red_step) begin
      base_r   <= red_next;
      data_r   <= {data_r[W-2:0], 1'b0};
      step_cnt <= (step_cnt == STEP_LAST) ? '0 : step_cnt + 1'b1;
    end
    if (cmd.mul_start) begin
      mula_r   <= base_r;
      mulb_r   <= cmd.mul_sel_prod ? prod_r : base_r;
      acc_r    <= '0;
      step_cnt <= '0;
    end
    if (cmd.mul_step) begin
      if (mulb_r[0]) begin
        acc_r <= acc_next;
      end
      mula_r   <= dbl_next;
      mulb_r   <= {1'b0, mulb_r[W-1:1]};
      step_cnt <= (step_cnt == STEP_LAST) ? '0 : step_cnt + 1'b1;
    end
    if (cmd.write_prod) begin
      prod_r <= acc_r;
    end
    if (cmd.write_base) begin
      base_r  <= acc_r;
      exp_r   <= {1'b0, exp_r[W-1:1]};
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  // Output register; valid holds until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= (mod_r == '0) ? '0 : prod_out;
      error  <= (mod_r == '0);
    end
  end

  // Status toward the controller.
  always_comb begin
    status.m_zero    = (mod_r == '0);
    status.exp_lsb   = exp_r[0];
    status.step_last = (step_cnt == STEP_LAST);
    status.bit_last  = (bit_cnt == STEP_LAST);
    status.out_busy  = out_valid && !out_ready;
  end

endmodule

[design/modexp_ctrl.sv]
// Controller: sequences reduction, square-and-multiply and result hand-off.
module modexp_ctrl import modexp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    hold,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = status.m_zero ? S_FINISH : S_REDUCE;
      end
      S_REDUCE: begin
        cmd.red_step = 1'b1;
        if (status.step_last) begin
          state_next = S_BIT;
        end
      end
      S_BIT: begin
        // While a square is written back, wait here; after the last bit the product is final.
        if (hold) begin
          if (status.bit_last) begin
            state_next = S_FINISH;
          end
        end else begin
          cmd.mul_start = 1'b1;
          if (status.exp_lsb) begin
            cmd.mul_sel_prod = 1'b1;
            state_next       = S_MUL_P;
          end else begin
            state_next = S_MUL_S;
          end
        end
      end
      S_MUL_P: begin
        cmd.mul_step = 1'b1;
        if (status.step_last) begin
          state_next = S_P_DONE;
        end
      end
      S_P_DONE: begin
        cmd.write_prod = 1'b1;
        cmd.mul_start  = 1'b1;
        state_next     = S_MUL_S;
      end
      S_MUL_S: begin
        cmd.mul_step = 1'b1;
        if (status.step_last) begin
          state_next = S_BIT;
        end
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/modexp_sq.sv]
// Square commit stage: tracks the cycle after a square and commits it to the base.
module modexp_sq import modexp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  input  cmd_t    cmd_in,
  output cmd_t    cmd_out,
  output logic    redirect
);

  logic sq_sel;
  logic sq_pend;

  // Remember whether the running multiply is a product, and flag the end of a square.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_sel  <= 1'b0;
      sq_pend <= 1'b0;
    end else begin
      if (cmd_in.mul_start) begin
        sq_sel <= cmd_in.mul_sel_prod;
      end
      sq_pend <= cmd_in.mul_step && !sq_sel && status.step_last;
    end
  end

  // In the cycle after a square finishes, the base is written and the controller waits.
  always_comb begin
    cmd_out  = cmd_in;
    redirect = sq_pend;
    if (sq_pend) begin
      cmd_out.write_base = 1'b1;
    end
  end

endmodule

[design/modular_exponentiation.sv]
// Top level of the modular exponentiation block: registers, controller and datapath.
//
//  channel  | direction | payload            | handshake
//  ---------+-----------+--------------------+--------------------------
//  in_ch    | in        | data_in[31:0]      | valid / ready
//  out_ch   | out       | result[31:0], error| valid / ready
//  config   | in        | cfg_index, cfg_data| cfg_we, no wait
//
// The data is reduced by the modulus, then each of the W = MOD_WIDTH exponent
// bits takes a square, preceded by a product when the bit is set, on the
// one-bit-per-cycle shift-and-add multiplier; the controller then returns to
// idle to take the next transaction. A zero modulus skips to an error result.
// Reset clears the controller, the output valid flag and the config registers
// (modulus 0, exponent 1). A result waits in the output register while the next
// transaction is accepted and computed; the controller holds only at the end.
module modular_exponentiation import modexp_pkg::*; #(
  parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  modexp_in_if.sink             in_ch,
  modexp_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data
);

  logic [DATA_WIDTH-1:0] modulus;
  logic [DATA_WIDTH-1:0] exponent;
  cmd_t    cmd_ctrl;
  cmd_t    cmd;
  status_t status;
  logic    redirect;
  logic    in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= '0;
      exponent <= DATA_WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS:  modulus  <= cfg_data;
        CFG_EXPONENT: exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  modexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .hold     (redirect),
    .status   (status),
    .cmd      (cmd_ctrl)
  );

  modexp_sq u_sq (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .cmd_in   (cmd_ctrl),
    .cmd_out  (cmd),
    .redirect (redirect)
  );

  assign in_ch.ready = in_ready;

  modexp_dp #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_modulus  (modulus),
    .cfg_exponent (exponent),
    .data_in      (in_ch.data_in),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .result       (out_ch.result),
    .error        (out_ch.error)
  );

endmodule
